// ===== rtl/core/ftts_pkg.sv =====
// Package for the fixed-timestep tick scheduler core.
// Holds status codes, register indexes, shared constants and the structs
// passed between the sequencer, the shared divider and the top level.
package ftts_pkg;

    localparam int ALPHA_FRACTION_BITS_DEF = 16;

    // Divider widths: the tick period and the tick rate both fit in 30 bits
    localparam int PERIOD_W = 30;
    localparam int WORD_W   = 64;

    localparam logic [PERIOD_W-1:0] NS_PER_SEC = 30'd1000000000;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_HZ = 2'd1;
    localparam logic [1:0] ST_LAG    = 2'd2;

    // Configuration register indexes
    localparam logic REG_TICK_HZ  = 1'b0;
    localparam logic REG_TICK_CAP = 1'b1;

    localparam logic [PERIOD_W-1:0] TICK_HZ_RESET  = 30'd60;
    localparam logic [31:0]         TICK_CAP_RESET = 32'd0;

    // Input kind carried on s_tuser
    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_RESET   = 1'b1;

    typedef struct packed {
        logic load;      // load dividend and divisor, clear quotient
        logic keep_rem;  // with load: continue from the current remainder
        logic step;      // one restoring division step
    } ftts_div_cmd_t;

    // First member sits in the highest bits, so status ends up at bit 0
    typedef struct packed {
        logic [15:0]         alpha;
        logic [PERIOD_W-1:0] rem_ns;
        logic [63:0]         batch_start_idx;
        logic [31:0]         tick_count;
        logic [1:0]          sticky_status;
        logic [1:0]          status;
    } ftts_result_t;

endpackage

// ===== rtl/core/ftts_div.sv =====
// Shared restoring divider: one quotient bit per step, MSB of the dividend first.
// Used for the period, the whole-tick split and the alpha fraction.
// Depends on ftts_pkg.
module ftts_div (
    input  logic                           aclk,
    input  ftts_pkg::ftts_div_cmd_t        cmd,
    input  logic [ftts_pkg::WORD_W-1:0]    dividend,
    input  logic [ftts_pkg::PERIOD_W-1:0]  divisor,
    output logic [ftts_pkg::WORD_W-1:0]    quotient,
    output logic [ftts_pkg::PERIOD_W-1:0]  remainder
);
    import ftts_pkg::*;

    logic [WORD_W-1:0]   dvd_reg, dvd_next;
    logic [WORD_W-1:0]   quo_reg, quo_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] dsr_reg, dsr_next;
    logic [PERIOD_W:0]   shifted;
    logic [PERIOD_W:0]   diff;
    logic                ge;

    always_comb begin
        shifted  = {rem_reg, dvd_reg[WORD_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        ge       = (shifted >= {1'b0, dsr_reg});
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (cmd.load) begin
            dvd_next = dividend;
            quo_next = '0;
            dsr_next = divisor;
            if (!cmd.keep_rem) begin
                rem_next = '0;
            end
        end else if (cmd.step) begin
            // remainder stays below the divisor, so it fits PERIOD_W bits
            rem_next = ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
            quo_next = {quo_reg[WORD_W-2:0], ge};
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/ftts_seq.sv =====
// Sequencer and loop state of the tick scheduler: baseline, elapsed time,
// accumulator, tick split, capping and alpha, all through one ftts_div.
// Depends on ftts_pkg and ftts_div.
module ftts_seq #(
    parameter int ALPHA_FRACTION_BITS = ftts_pkg::ALPHA_FRACTION_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [ftts_pkg::PERIOD_W-1:0]  tick_hz,
    input  logic [31:0]                    tick_cap,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_action,
    input  logic [63:0]                    in_now,
    output logic                           res_valid,
    input  logic                           res_ready,
    output ftts_pkg::ftts_result_t         res
);
    import ftts_pkg::*;

    localparam int PER_STEPS = PERIOD_W;
    localparam int WH_STEPS  = WORD_W;
    localparam int FR_STEPS  = ALPHA_FRACTION_BITS;
    localparam int CNT_W     = $clog2(WH_STEPS) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ELAPSED,
        S_ACCUM,
        S_PER_LD,
        S_PER_RUN,
        S_WH_LD,
        S_WH_RUN,
        S_FR_LD,
        S_FR_RUN,
        S_FINISH,
        S_ADVANCE,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                started_reg;
    logic [63:0]         last_reg;
    logic [63:0]         acc_reg;
    logic [63:0]         tick_index_reg;
    logic [1:0]          loop_status_reg;
    logic [63:0]         now_reg;
    logic [63:0]         elapsed_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [63:0]         whole_reg;
    ftts_result_t        res_reg;

    ftts_div_cmd_t       div_cmd;
    logic [WORD_W-1:0]   div_dividend;
    logic [PERIOD_W-1:0] div_divisor;
    logic [WORD_W-1:0]   div_quo;
    logic [PERIOD_W-1:0] div_rem;

    logic                hz_bad;
    logic [64:0]         diff;
    logic                over_max;
    logic                over_u32;
    logic                lag_hit;
    logic [15:0]         alpha_sat;
    ftts_result_t        rst_res;
    ftts_result_t        base_res;
    ftts_result_t        acc_res;
    ftts_result_t        fin_res;

    ftts_div u_div (
        .aclk      (aclk),
        .cmd       (div_cmd),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        hz_bad    = (tick_hz == '0) || (tick_hz > NS_PER_SEC);
        diff      = {1'b0, now_reg} - {1'b0, last_reg};
        over_max  = (tick_cap != '0) && (whole_reg > {32'd0, tick_cap});
        over_u32  = (whole_reg[63:32] != '0);
        lag_hit   = over_max || over_u32;
        alpha_sat = (div_quo > 64'hFFFF) ? 16'hFFFF : div_quo[15:0];

        rst_res               = '0;
        rst_res.status        = ST_OK;
        rst_res.sticky_status = hz_bad ? ST_BAD_HZ : ST_OK;

        base_res                 = '0;
        base_res.status          = ST_OK;
        base_res.sticky_status   = loop_status_reg;
        base_res.batch_start_idx = tick_index_reg;

        acc_res                 = '0;
        acc_res.batch_start_idx = tick_index_reg;
        if (hz_bad) begin
            acc_res.status        = ST_BAD_HZ;
            acc_res.sticky_status = ST_BAD_HZ;
        end

        fin_res        = res_reg;
        fin_res.rem_ns = acc_reg[PERIOD_W-1:0];
        fin_res.alpha  = alpha_sat;
        if (over_max) begin
            fin_res.tick_count = tick_cap;
        end else if (over_u32) begin
            fin_res.tick_count = 32'hFFFF_FFFF;
        end else begin
            fin_res.tick_count = whole_reg[31:0];
        end
        fin_res.status        = lag_hit ? ST_LAG : ST_OK;
        fin_res.sticky_status = lag_hit ? ST_LAG : loop_status_reg;

        div_cmd          = '0;
        div_cmd.load     = (state_reg == S_PER_LD) || (state_reg == S_WH_LD) ||
                           (state_reg == S_FR_LD);
        div_cmd.keep_rem = (state_reg == S_FR_LD);
        div_cmd.step     = (state_reg == S_PER_RUN) || (state_reg == S_WH_RUN) ||
                           (state_reg == S_FR_RUN);

        case (state_reg)
            S_PER_LD: begin
                div_dividend = {NS_PER_SEC, {(WORD_W-PERIOD_W){1'b0}}};
                div_divisor  = tick_hz;
            end
            S_WH_LD: begin
                div_dividend = acc_reg;
                div_divisor  = div_quo[PERIOD_W-1:0];
            end
            default: begin
                div_dividend = '0;
                div_divisor  = period_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            started_reg     <= 1'b0;
            last_reg        <= '0;
            acc_reg         <= '0;
            tick_index_reg  <= '0;
            loop_status_reg <= ST_OK;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        if (in_action == ACT_RESET) begin
                            loop_status_reg <= hz_bad ? ST_BAD_HZ : ST_OK;
                            started_reg     <= 1'b0;
                            last_reg        <= '0;
                            acc_reg         <= '0;
                            tick_index_reg  <= '0;
                            res_reg         <= rst_res;
                            state_reg       <= S_EMIT;
                        end else if (!started_reg) begin
                            // baseline only: the accumulator is still clear here
                            started_reg <= 1'b1;
                            last_reg    <= in_now;
                            res_reg     <= base_res;
                            state_reg   <= S_EMIT;
                        end else begin
                            now_reg   <= in_now;
                            state_reg <= S_ELAPSED;
                        end
                    end
                end
                S_ELAPSED: begin
                    // time going backwards counts as no time
                    elapsed_reg <= diff[64] ? 64'd0 : diff[63:0];
                    last_reg    <= now_reg;
                    state_reg   <= S_ACCUM;
                end
                S_ACCUM: begin
                    acc_reg <= acc_reg + elapsed_reg;
                    res_reg <= acc_res;
                    if (hz_bad) begin
                        loop_status_reg <= ST_BAD_HZ;
                        state_reg       <= S_EMIT;
                    end else begin
                        state_reg <= S_PER_LD;
                    end
                end
                S_PER_LD: begin
                    cnt_reg   <= '0;
                    state_reg <= S_PER_RUN;
                end
                S_PER_RUN: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(PER_STEPS - 1)) begin
                        state_reg <= S_WH_LD;
                    end
                end
                S_WH_LD: begin
                    period_reg <= div_quo[PERIOD_W-1:0];
                    cnt_reg    <= '0;
                    state_reg  <= S_WH_RUN;
                end
                S_WH_RUN: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(WH_STEPS - 1)) begin
                        state_reg <= S_FR_LD;
                    end
                end
                S_FR_LD: begin
                    whole_reg <= div_quo;
                    acc_reg   <= {{(64-PERIOD_W){1'b0}}, div_rem};
                    cnt_reg   <= '0;
                    state_reg <= S_FR_RUN;
                end
                S_FR_RUN: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(FR_STEPS - 1)) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    res_reg <= fin_res;
                    if (lag_hit) begin
                        loop_status_reg <= ST_LAG;
                    end
                    state_reg <= S_ADVANCE;
                end
                S_ADVANCE: begin
                    tick_index_reg <= tick_index_reg + {32'd0, res_reg.tick_count};
                    state_reg      <= S_EMIT;
                end
                S_EMIT: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && aresetn;
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

    a_idle_loop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !started_reg |-> (acc_reg == '0) && (tick_index_reg == '0))
        else $error("loop not started but accumulator or tick index nonzero");

    a_period_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WH_RUN) |-> (period_reg != '0))
        else $error("whole-tick division running with a zero period");

    a_rem_below_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH) |-> (acc_reg < {{(64-PERIOD_W){1'b0}}, period_reg}))
        else $error("leftover not below the tick period");

endmodule

// ===== rtl/core/fixed_timestep_tick_scheduler_core.sv =====
// Top level of the fixed-timestep tick scheduler: configuration registers,
// stream ports and the result register. Depends on ftts_pkg and ftts_seq.
//
//  channel | direction | tdata                   | tuser  | accept
//  s_      | in        | now_ns                  | action | s_tvalid & s_tready
//  m_      | out       | status .. alpha, packed | -      | m_tvalid & m_tready
//  cfg_    | in        | cfg_wdata               | -      | cfg_wr_en
//
// A reset or baseline transaction goes from S_IDLE straight to S_EMIT.
// An advance passes S_ELAPSED and S_ACCUM, then the shared divider forms 30 quotient
// bits for the period, 64 for the whole ticks and ALPHA_FRACTION_BITS for the alpha
// fraction, and S_FINISH and S_ADVANCE lead on to S_EMIT.
// An advance with a tick rate of zero or above 1e9 reports bad without the divider.
// Reset is synchronous; one result waits in the output register while the
// next transaction is accepted, and a stalled output holds the sequencer.
module fixed_timestep_tick_scheduler_core #(
    parameter int ALPHA_FRACTION_BITS = ftts_pkg::ALPHA_FRACTION_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [63:0] now_ns
    input  logic         s_tuser,   // [0] action
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] status, [3:2] sticky_status, [35:4] tick count,
    // [99:36] first tick index, [129:100] remainder ns, [145:130] alpha, rest zero
    output logic [151:0] m_tdata
);
    import ftts_pkg::*;

    localparam int PAD_W = 152 - $bits(ftts_result_t);

    logic [PERIOD_W-1:0] tick_hz_reg;
    logic [31:0]         tick_cap_reg;
    logic                out_valid_reg;
    ftts_result_t        out_reg;

    logic                res_valid;
    logic                res_ready;
    ftts_result_t        res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_hz_reg  <= TICK_HZ_RESET;
            tick_cap_reg <= TICK_CAP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TICK_HZ:  tick_hz_reg  <= cfg_wdata[PERIOD_W-1:0];
                REG_TICK_CAP: tick_cap_reg <= cfg_wdata;
                default:      tick_hz_reg  <= tick_hz_reg;
            endcase
        end
    end

    ftts_seq #(
        .ALPHA_FRACTION_BITS (ALPHA_FRACTION_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_hz   (tick_hz_reg),
        .tick_cap  (tick_cap_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_now    (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // take a new result when the output register is empty or draining
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_reg};

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new transaction accepted right after another");

endmodule
